>>> sv/logistic_neuron_sgd_trainer_unit_assert.svh
// Concurrent check macros, sampled on the rising clock, off during reset
`ifndef LOGISTIC_NEURON_SGD_TRAINER_UNIT_ASSERT_SVH
`define LOGISTIC_NEURON_SGD_TRAINER_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define LNSGD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define LNSGD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lnsgd_pkg.sv
package lnsgd_pkg;

   localparam int MAX_INPUTS      = 16;
   localparam int SLOT_W          = $clog2(MAX_INPUTS);
   localparam int IDX_W           = 5;
   localparam int SIGMOID_ENTRIES = 256;
   localparam int SIG_STEP        = 65536 / SIGMOID_ENTRIES;
   localparam int TIX_W           = $clog2(SIGMOID_ENTRIES);
   localparam int ACC_W           = 40;
   localparam int GAIN_W          = 33;
   localparam logic [15:0] LR_RESET = 16'd6554;

   localparam logic [1:0] FUNC_INFER = 2'd0;
   localparam logic [1:0] FUNC_TRAIN = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam logic [1:0] KIND_INFER = 2'd0;
   localparam logic [1:0] KIND_TRAIN = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef struct packed {
      logic load_w;
      logic load_x;
      logic shift;
      logic clear_v;
   } cell_ctrl_type;

   typedef logic [15:0] sig_tbl_type [SIGMOID_ENTRIES];

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      begin
         rem = '0;
         quo = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
               rem    = rem - {1'b0, den};
               quo[b] = 1'b1;
            end
         end
         return quo;
      end
   endfunction

   function automatic logic [63:0] exp_neg(input logic [31:0] a);
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] term;
      begin
         t    = {32'b0, a} << 16;
         sum  = 64'h1_0000_0000;
         term = 64'h1_0000_0000;
         for (int n = 1; n <= 12; n++) begin
            term = udiv64((term * t) >> 32, 64'(n));
            if ((n & 1) != 0) sum = sum - term;
            else sum = sum + term;
         end
         for (int k = 0; k < 4; k++) begin
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            sum = (sum * sum) >> 32;
         end
         return sum;
      end
   endfunction

   function automatic logic [15:0] sigmoid_q16(input int x);
      logic [31:0] a;
      logic [63:0] d;
      logic [63:0] y;
      begin
         a = (x < 0) ? 32'(-x) : 32'(x);
         d = 64'h1_0000_0000 + exp_neg(a);
         y = udiv64((64'h1 << 48) + (d >> 1), d);
         if (y > 64'd65535) y = 64'd65535;
         if (x < 0) y = 64'd65536 - y;
         if (y > 64'd65535) y = 64'd65535;
         return y[15:0];
      end
   endfunction

   function automatic sig_tbl_type build_sig_table();
      sig_tbl_type tbl;
      begin
         for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            tbl[i] = sigmoid_q16(-32768 + i * SIG_STEP);
         end
         return tbl;
      end
   endfunction

   localparam sig_tbl_type SIG_TABLE = build_sig_table();

endpackage

>>> sv/lnsgd_cell.sv
module lnsgd_cell
   import lnsgd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic signed [15:0]  load_data,
   input  logic signed [15:0]  next_w,
   input  logic signed [15:0]  next_x,
   input  logic                next_v,
   output logic signed [15:0]  w,
   output logic signed [15:0]  x,
   output logic                v
);

   logic signed [15:0] w_ff;
   logic signed [15:0] x_ff;
   logic               v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
         v_ff <= 1'b0;
      end else if (ctrl.shift) begin
         w_ff <= next_w;
         v_ff <= next_v;
      end else begin
         if (ctrl.load_w) w_ff <= load_data;
         if (ctrl.clear_v) v_ff <= 1'b0;
         else if (ctrl.load_x) v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) x_ff <= next_x;
      else if (ctrl.load_x) x_ff <= load_data;
   end

   assign w = w_ff;
   assign x = x_ff;
   assign v = v_ff;

endmodule

>>> sv/lnsgd_update.sv
module lnsgd_update
   import lnsgd_pkg::*;
(
   input  logic signed [GAIN_W-1:0] gain,
   input  logic signed [15:0]       w_in,
   input  logic signed [15:0]       x_in,
   input  logic                     v_in,
   output logic signed [15:0]       w_out
);

   logic signed [15:0]          x_eff;
   logic signed [GAIN_W+15:0]   prod;
   logic signed [GAIN_W-17:0]   step;
   logic signed [GAIN_W-16:0]   sum;

   always_comb begin
      x_eff = v_in ? x_in : 16'sd0;
      prod  = gain * x_eff;
      step  = prod[GAIN_W+15:32];
      sum   = (GAIN_W-15)'(w_in) + (GAIN_W-15)'(step);
      if (sum > 32767) w_out = 16'sh7FFF;
      else if (sum < -32768) w_out = -16'sh8000;
      else w_out = sum[15:0];
   end

endmodule

>>> sv/logistic_neuron_sgd_trainer_unit.sv
// Element beat: multiply on accept, accumulate next; busy covers the add.
// Last element, infer: a table lookup state follows the add and strobes the result.
// Last element, train: lookup, error math in ST_ERR, ST_DELTA and ST_GAIN, then the weight
// update ring in ST_UPD, after which the result strobes. Results are never held off.
// Write stays idle, no result; read strobes its result the cycle after accept.
// Synchronous reset: weights, bias and accumulator zero, learning rate 6554.
`include "logistic_neuron_sgd_trainer_unit_assert.svh"
module logistic_neuron_sgd_trainer_unit
   import lnsgd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_sample_value,
   input  logic [IDX_W-1:0]   req_param_index,
   input  logic               req_last_element,
   input  logic [15:0]        req_target,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_result_kind,
   output logic [15:0]        rsp_prediction,
   output logic [15:0]        rsp_squared_error,
   output logic signed [15:0] rsp_read_value
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD, ST_LOOK, ST_ERR, ST_DELTA, ST_GAIN, ST_UPD
   } state_type;

   state_type                 state_ff;
   logic [1:0]                func_ff;
   logic                      last_ff;
   logic                      hit_ff;
   logic [15:0]               target_ff;
   logic signed [31:0]        prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [IDX_W-1:0]          cnt_ff;
   logic signed [15:0]        bias_ff;
   logic [15:0]               lr_ff;
   logic [15:0]               y_ff;
   logic signed [16:0]        err_ff;
   logic [16:0]               yd_ff;
   logic [15:0]               sq_ff;
   logic signed [16:0]        delta_ff;
   logic signed [GAIN_W-1:0]  gain_ff;
   logic [SLOT_W-1:0]         pass_ff;
   logic                      rsp_strobe_ff;
   logic [1:0]                rsp_kind_ff;
   logic [15:0]               rsp_pred_ff;
   logic [15:0]               rsp_sq_ff;
   logic signed [15:0]        rsp_read_ff;

   logic                      accept;
   logic                      in_range;
   logic                      is_bias;
   logic [SLOT_W-1:0]         slot;
   logic signed [15:0]        w_sel;
   logic signed [ACC_W-1:0]   acc_base;
   logic signed [ACC_W:0]     acc_sum;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-13:0]  acc_shift;
   logic signed [15:0]        sum16;
   logic [TIX_W-1:0]          tix;
   logic signed [16:0]        err_in;
   logic [33:0]               sq_full;
   logic [33:0]               yd_full;
   logic signed [34:0]        delta_full;
   logic signed [34:0]        gain_full;
   logic signed [GAIN_W-21:0] bias_step;
   logic signed [16:0]        bias_sum;
   logic signed [15:0]        bias_in;
   logic signed [15:0]        upd_w;

   logic signed [15:0]        cw [MAX_INPUTS];
   logic signed [15:0]        cx [MAX_INPUTS];
   logic                      cv [MAX_INPUTS];
   cell_ctrl_type             cctrl [MAX_INPUTS];

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = (req_param_index < IDX_W'(MAX_INPUTS));
   assign is_bias  = (req_param_index == IDX_W'(MAX_INPUTS));
   assign slot     = req_param_index[SLOT_W-1:0];
   assign w_sel    = in_range ? cw[slot] : 16'sd0;

   always_comb begin
      for (int j = 0; j < MAX_INPUTS; j++) begin
         cctrl[j].shift   = (state_ff == ST_UPD);
         cctrl[j].load_w  = accept && (req_func == FUNC_WRITE) && in_range
                            && (slot == SLOT_W'(j));
         cctrl[j].load_x  = accept && ((req_func == FUNC_INFER) || (req_func == FUNC_TRAIN))
                            && in_range && (slot == SLOT_W'(j));
         cctrl[j].clear_v = (state_ff == ST_LOOK) && (func_ff != FUNC_TRAIN);
      end
   end

   for (genvar j = 0; j < MAX_INPUTS; j++) begin : g_cell
      if (j == MAX_INPUTS - 1) begin : g_tail
         lnsgd_cell u_cell (
            .clock(clock), .reset(reset), .ctrl(cctrl[j]), .load_data(req_sample_value),
            .next_w(upd_w), .next_x(16'sd0), .next_v(1'b0),
            .w(cw[j]), .x(cx[j]), .v(cv[j])
         );
      end else begin : g_body
         lnsgd_cell u_cell (
            .clock(clock), .reset(reset), .ctrl(cctrl[j]), .load_data(req_sample_value),
            .next_w(cw[j+1]), .next_x(cx[j+1]), .next_v(cv[j+1]),
            .w(cw[j]), .x(cx[j]), .v(cv[j])
         );
      end
   end

   lnsgd_update u_update (
      .gain(gain_ff), .w_in(cw[0]), .x_in(cx[0]), .v_in(cv[0]), .w_out(upd_w)
   );

   always_comb begin
      acc_base = ((cnt_ff == '0) && (acc_ff == '0))
                 ? {{(ACC_W-28){bias_ff[15]}}, bias_ff, 12'b0} : acc_ff;
      acc_sum  = (ACC_W+1)'(acc_base) + (hit_ff ? (ACC_W+1)'(prod_ff) : '0);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
         acc_in = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
         acc_in = acc_sum[ACC_W-1:0];
      acc_shift = acc_ff[ACC_W-1:12];
      if (acc_shift > 32767) sum16 = 16'sh7FFF;
      else if (acc_shift < -32768) sum16 = -16'sh8000;
      else sum16 = acc_shift[15:0];
      tix        = {~sum16[15], sum16[14:16-TIX_W]};
      err_in     = $signed({1'b0, target_ff}) - $signed({1'b0, y_ff});
      sq_full    = 34'(err_in) * 34'(err_in);
      yd_full    = {18'b0, y_ff} * (34'd65536 - {18'b0, y_ff});
      delta_full = 35'(err_ff) * 35'($signed({1'b0, yd_ff}));
      gain_full  = 35'($signed({1'b0, lr_ff})) * 35'(delta_ff);
      bias_step  = gain_ff[GAIN_W-1:20];
      bias_sum   = 17'(bias_ff) + 17'(bias_step);
      if (bias_sum > 32767) bias_in = 16'sh7FFF;
      else if (bias_sum < -32768) bias_in = -16'sh8000;
      else bias_in = bias_sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         acc_ff        <= '0;
         cnt_ff        <= '0;
         bias_ff       <= '0;
         lr_ff         <= LR_RESET;
         pass_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_write_enable) lr_ff <= csr_write_data;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  func_ff   <= req_func;
                  last_ff   <= req_last_element;
                  hit_ff    <= in_range;
                  target_ff <= req_target;
                  prod_ff   <= req_sample_value * w_sel;
                  case (req_func)
                     FUNC_WRITE: begin
                        if (is_bias) bias_ff <= req_sample_value;
                     end
                     FUNC_READ: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_kind_ff   <= KIND_READ;
                        rsp_pred_ff   <= '0;
                        rsp_sq_ff     <= '0;
                        rsp_read_ff   <= in_range ? w_sel : (is_bias ? bias_ff : 16'sd0);
                     end
                     default: state_ff <= ST_ADD;
                  endcase
               end
            end
            ST_ADD: begin
               acc_ff <= acc_in;
               if (hit_ff && (cnt_ff < IDX_W'(MAX_INPUTS))) cnt_ff <= cnt_ff + 1'b1;
               state_ff <= last_ff ? ST_LOOK : ST_IDLE;
            end
            ST_LOOK: begin
               y_ff <= SIG_TABLE[tix];
               if (func_ff == FUNC_TRAIN) begin
                  state_ff <= ST_ERR;
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_kind_ff   <= KIND_INFER;
                  rsp_pred_ff   <= SIG_TABLE[tix];
                  rsp_sq_ff     <= '0;
                  rsp_read_ff   <= '0;
                  acc_ff        <= '0;
                  cnt_ff        <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_ERR: begin
               err_ff   <= err_in;
               sq_ff    <= sq_full[31:16];
               yd_ff    <= yd_full[32:16];
               state_ff <= ST_DELTA;
            end
            ST_DELTA: begin
               delta_ff <= delta_full[32:16];
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               gain_ff  <= gain_full[GAIN_W-1:0];
               pass_ff  <= '0;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (pass_ff == '0) bias_ff <= bias_in;
               pass_ff <= pass_ff + 1'b1;
               if (pass_ff == SLOT_W'(MAX_INPUTS - 1)) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_kind_ff   <= KIND_TRAIN;
                  rsp_pred_ff   <= y_ff;
                  rsp_sq_ff     <= sq_ff;
                  rsp_read_ff   <= '0;
                  acc_ff        <= '0;
                  cnt_ff        <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_prediction    = rsp_pred_ff;
   assign rsp_squared_error = rsp_sq_ff;
   assign rsp_read_value    = rsp_read_ff;

   `LNSGD_ASSERT_NOW(a_read_clean, rsp_strobe && (rsp_result_kind == KIND_READ),
      (rsp_prediction == 16'd0) && (rsp_squared_error == 16'd0), "read beat carries data")
   `LNSGD_ASSERT_NEXT(a_elem_busy, accept && ((req_func == FUNC_INFER) ||
      (req_func == FUNC_TRAIN)), busy, "element beat did not hold busy")
   `LNSGD_ASSERT_NEXT(a_upd_ends, (state_ff == ST_UPD) && (pass_ff == SLOT_W'(MAX_INPUTS - 1)),
      rsp_strobe && (rsp_result_kind == KIND_TRAIN) && !busy, "update pass lost its result")

endmodule
